// File: design/usc_pkg.sv
// Shared constants, types and small tables for the Unix time to calendar converter.
`timescale 1ns / 1ps
package usc_pkg;

  // Pipeline depth: one valid bit and one load enable per register stage.
  localparam int NSTG = 10;

  // Field widths of the two channels.
  localparam int STAMP_W = 32;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int WDAY_W  = 3;

  // Reciprocals for exact division by constants: q = (x * RCP) >> SH.
  // Each one is ceil(2^SH / d) with SH = (bits of x) + ceil(log2 d).
  localparam logic [25:0] RCP_675   = 26'd50903317;  // x < 2^25, SH = 35
  localparam logic [9:0]  D675      = 10'd675;
  localparam logic [16:0] RCP_7     = 17'd74899;     // x < 2^16, SH = 19
  localparam logic [16:0] RCP_365Q  = 17'd91930;     // x < 2^16, SH = 25
  localparam logic [17:0] RCP_60S   = 18'd139811;    // x < 2^17, SH = 23
  localparam logic [11:0] RCP_60M   = 12'd2185;      // x < 2^11, SH = 17
  localparam logic [18:0] RCP_365   = 19'd367720;    // x < 2^18, SH = 27
  localparam logic [9:0]  RCP_100   = 10'd656;       // x < 2^9,  SH = 16
  localparam logic [11:0] RCP_153   = 12'd3427;      // x < 2^11, SH = 19
  localparam logic [8:0]  DAYS_YEAR = 9'd365;

  // Day numbers from 1970-01-01 fall in the 400-year cycles that start in
  // 1600 and 2000. The second one starts at day 11017.
  localparam logic [15:0] CYC5_DAY  = 16'd11017;
  localparam logic [17:0] CYC4_OFS  = 18'd135080;

  // Century boundaries inside a 400-year cycle, counted in days.
  localparam logic [17:0] DOC_C1 = 18'd36524;
  localparam logic [17:0] DOC_C2 = 18'd73048;
  localparam logic [17:0] DOC_C3 = 18'd109572;
  localparam logic [17:0] DOC_C4 = 18'd146096;

  localparam logic [YEAR_W-1:0] CYC4_YEAR = 12'd1600;
  localparam logic [YEAR_W-1:0] CYC5_YEAR = 12'd2000;
  localparam logic [YEAR_W-1:0] YEAR_LO   = 12'd2000;
  localparam logic [YEAR_W-1:0] YEAR_HI   = 12'd2099;

  localparam logic [3:0] MP_JAN = 4'd10;

  typedef struct packed {
    logic [NSTG-1:0] load;
    logic [NSTG-1:0] valid;
  } pipe_ctl_t;

  // First day of a March-based month, counted from March 1.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Weekday from the day number modulo 7; day 0 was a Thursday.
  function automatic logic [WDAY_W-1:0] wday_of(input logic [2:0] r7);
    logic [WDAY_W-1:0] w;
    case (r7)
      3'd0:    w = 3'd4;
      3'd1:    w = 3'd5;
      3'd2:    w = 3'd6;
      3'd3:    w = 3'd7;
      3'd4:    w = 3'd1;
      3'd5:    w = 3'd2;
      3'd6:    w = 3'd3;
      default: w = 3'd1;
    endcase
    return w;
  endfunction

endpackage

// File: design/usc_if.sv
// Valid/ready channel interfaces for timestamps in and calendar words out.
`timescale 1ns / 1ps
interface usc_stamp_if;
  logic                        valid;
  logic                        ready;
  logic [usc_pkg::STAMP_W-1:0] unix_seconds;

  modport source (output valid, output unix_seconds, input ready);
  modport sink (input valid, input unix_seconds, output ready);
endinterface

interface usc_cal_if;
  logic                       valid;
  logic                       ready;
  logic [usc_pkg::YEAR_W-1:0]  year;
  logic [usc_pkg::MONTH_W-1:0] month;
  logic [usc_pkg::DAY_W-1:0]   day;
  logic [usc_pkg::HOUR_W-1:0]  hour;
  logic [usc_pkg::MIN_W-1:0]   minute;
  logic [usc_pkg::SEC_W-1:0]   second;
  logic [usc_pkg::WDAY_W-1:0]  weekday;
  logic                       in_range;

  modport source (output valid, output year, output month, output day, output hour,
                  output minute, output second, output weekday, output in_range,
                  input ready);
  modport sink (input valid, input year, input month, input day, input hour,
                input minute, input second, input weekday, input in_range,
                output ready);
endinterface

// File: design/usc_pipe_ctl.sv
// Valid bits and per-stage load enables for the converter pipeline.
`timescale 1ns / 1ps
module usc_pipe_ctl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               out_ready,
  output usc_pkg::pipe_ctl_t ctl
);

  logic [usc_pkg::NSTG-1:0] valid;
  logic [usc_pkg::NSTG-1:0] load;

  // A stage may load when it is empty or when the stage after it moves.
  always_comb begin
    load[usc_pkg::NSTG-1] = !valid[usc_pkg::NSTG-1] || out_ready;
    for (int i = usc_pkg::NSTG - 2; i >= 0; i--) begin
      load[i] = !valid[i] || load[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (load[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < usc_pkg::NSTG; i++) begin
        if (load[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign ctl.load  = load;
  assign ctl.valid = valid;

endmodule

// File: design/unix_seconds_to_calendar.sv
// Top level: ten-stage pipeline from Unix seconds to Gregorian date, time and weekday.
`timescale 1ns / 1ps
// A word accepted at the input moves through every stage register in turn and then
// waits in the output register until the receiver takes it.
// Throughput: one word per cycle while the receiver takes words; no stage holds more
// than two constant multipliers. Each stage has its own load enable, so bubbles close
// up and words keep entering empty stages while a finished result waits on the output
// register. Reset (synchronous, active high) clears only the stage valid bits.
module unix_seconds_to_calendar (
  input logic           clk,
  input logic           rst,
  usc_stamp_if.sink     stamp,
  usc_cal_if.source     calendar
);

  usc_pkg::pipe_ctl_t ctl;

  usc_pipe_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stamp.valid),
    .out_ready (calendar.ready),
    .ctl       (ctl)
  );

  assign stamp.ready    = ctl.load[0];
  assign calendar.valid = ctl.valid[usc_pkg::NSTG-1];

  // Stage 1: the day number is stamp / 86400 = (stamp >> 7) / 675, so only the
  // upper 25 bits go through the reciprocal multiply.
  logic [24:0] s1_x;
  logic [6:0]  s1_lo;
  logic [50:0] s1_p;

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      s1_x  <= stamp.unix_seconds[31:7];
      s1_lo <= stamp.unix_seconds[6:0];
      s1_p  <= 51'(stamp.unix_seconds[31:7]) * 51'(usc_pkg::RCP_675);
    end
  end

  // Stage 2: take the day number and form day * 675 for the remainder.
  logic [15:0] dayno2;
  logic [15:0] s2_dayno;
  logic [25:0] s2_qm;
  logic [24:0] s2_x;
  logic [6:0]  s2_lo;

  assign dayno2 = s1_p[50:35];

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      s2_dayno <= dayno2;
      s2_qm    <= 26'(dayno2) * 26'(usc_pkg::D675);
      s2_x     <= s1_x;
      s2_lo    <= s1_lo;
    end
  end

  // Stage 3: second of the day, and the day within the 400-year cycle. Only the
  // cycles from 1600 and from 2000 are reachable, so one compare picks the cycle.
  // The weekday division by seven starts here as well.
  logic [24:0] rem3;
  logic        cyc5_3;
  logic [16:0] s3_sod;
  logic        s3_cyc5;
  logic [17:0] s3_doc;
  logic [32:0] s3_pw;
  logic [15:0] s3_dayno;

  assign rem3   = s2_x - s2_qm[24:0];
  assign cyc5_3 = (s2_dayno >= usc_pkg::CYC5_DAY);

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      s3_sod   <= {rem3[9:0], s2_lo};
      s3_cyc5  <= cyc5_3;
      s3_doc   <= cyc5_3 ? 18'(s2_dayno - usc_pkg::CYC5_DAY)
                         : 18'(s2_dayno) + usc_pkg::CYC4_OFS;
      s3_pw    <= 33'(s2_dayno) * 33'(usc_pkg::RCP_7);
      s3_dayno <= s2_dayno;
    end
  end

  // Stage 4: weekday from the day number modulo 7; minute of the day and the
  // doc / 1460 term start their multiplies; the century count comes from four
  // compares against the century boundaries.
  logic [13:0] q7;
  logic [16:0] q7x7;
  logic [16:0] r7;
  logic [2:0]  cent4;
  logic [34:0] s4_ps;
  logic [16:0] s4_sod;
  logic [32:0] s4_pd;
  logic [2:0]  s4_c36;
  logic        s4_c146;
  logic [17:0] s4_doc;
  logic        s4_cyc5;
  logic [usc_pkg::WDAY_W-1:0] s4_wd;

  assign q7    = s3_pw[32:19];
  assign q7x7  = {q7, 3'b000} - {3'b000, q7};
  assign r7    = {1'b0, s3_dayno} - q7x7;
  assign cent4 = 3'((s3_doc >= usc_pkg::DOC_C1)) + 3'((s3_doc >= usc_pkg::DOC_C2))
               + 3'((s3_doc >= usc_pkg::DOC_C3)) + 3'((s3_doc >= usc_pkg::DOC_C4));

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      s4_wd   <= usc_pkg::wday_of(r7[2:0]);
      s4_ps   <= 35'(s3_sod) * 35'(usc_pkg::RCP_60S);
      s4_sod  <= s3_sod;
      s4_pd   <= 33'(s3_doc[17:2]) * 33'(usc_pkg::RCP_365Q);
      s4_c36  <= cent4;
      s4_c146 <= (s3_doc == usc_pkg::DOC_C4);
      s4_doc  <= s3_doc;
      s4_cyc5 <= s3_cyc5;
    end
  end

  // Stage 5: seconds fall out of the minute of the day; the hour multiply
  // starts. On the date side the leap-corrected day count is formed, which
  // divided by 365 gives the year within the cycle.
  logic [10:0] mtot5;
  logic [16:0] mtot60;
  logic [16:0] sec5;
  logic [6:0]  q1460;
  logic [22:0] s5_ph;
  logic [10:0] s5_mtot;
  logic [usc_pkg::SEC_W-1:0]  s5_sec;
  logic [17:0] s5_num;
  logic [17:0] s5_doc;
  logic        s5_cyc5;
  logic [usc_pkg::WDAY_W-1:0] s5_wd;

  assign mtot5  = s4_ps[33:23];
  assign mtot60 = {mtot5, 6'b000000} - {4'b0000, mtot5, 2'b00};
  assign sec5   = s4_sod - mtot60;
  assign q1460  = s4_pd[31:25];

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      s5_ph   <= 23'(mtot5) * 23'(usc_pkg::RCP_60M);
      s5_mtot <= mtot5;
      s5_sec  <= sec5[5:0];
      s5_num  <= s4_doc - 18'(q1460) + 18'(s4_c36) - 18'(s4_c146);
      s5_doc  <= s4_doc;
      s5_cyc5 <= s4_cyc5;
      s5_wd   <= s4_wd;
    end
  end

  // Stage 6: hour and minute; the year-within-cycle multiply.
  logic [4:0]  hour6;
  logic [10:0] hour60;
  logic [10:0] min6;
  logic [36:0] s6_py;
  logic [17:0] s6_doc;
  logic        s6_cyc5;
  logic [usc_pkg::HOUR_W-1:0] s6_hour;
  logic [usc_pkg::MIN_W-1:0]  s6_min;
  logic [usc_pkg::SEC_W-1:0]  s6_sec;
  logic [usc_pkg::WDAY_W-1:0] s6_wd;

  assign hour6  = s5_ph[21:17];
  assign hour60 = {hour6, 6'b000000} - {4'b0000, hour6, 2'b00};
  assign min6   = s5_mtot - hour60;

  always_ff @(posedge clk) begin
    if (ctl.load[5]) begin
      s6_py   <= 37'(s5_num) * 37'(usc_pkg::RCP_365);
      s6_doc  <= s5_doc;
      s6_cyc5 <= s5_cyc5;
      s6_hour <= hour6;
      s6_min  <= min6[5:0];
      s6_sec  <= s5_sec;
      s6_wd   <= s5_wd;
    end
  end

  // Stage 7: year within the cycle; the days before its start need 365 * y and y / 100.
  logic [8:0]  yoc7;
  logic [8:0]  s7_yoc;
  logic [17:0] s7_p365;
  logic [18:0] s7_p100;
  logic [17:0] s7_doc;
  logic        s7_cyc5;
  logic [usc_pkg::HOUR_W-1:0] s7_hour;
  logic [usc_pkg::MIN_W-1:0]  s7_min;
  logic [usc_pkg::SEC_W-1:0]  s7_sec;
  logic [usc_pkg::WDAY_W-1:0] s7_wd;

  assign yoc7 = s6_py[35:27];

  always_ff @(posedge clk) begin
    if (ctl.load[6]) begin
      s7_yoc  <= yoc7;
      s7_p365 <= 18'(yoc7) * 18'(usc_pkg::DAYS_YEAR);
      s7_p100 <= 19'(yoc7) * 19'(usc_pkg::RCP_100);
      s7_doc  <= s6_doc;
      s7_cyc5 <= s6_cyc5;
      s7_hour <= s6_hour;
      s7_min  <= s6_min;
      s7_sec  <= s6_sec;
      s7_wd   <= s6_wd;
    end
  end

  // Stage 8: day within the March-based year.
  logic [1:0]  y100;
  logic [17:0] ybase;
  logic [17:0] doy8;
  logic [8:0]  s8_doy;
  logic [8:0]  s8_yoc;
  logic        s8_cyc5;
  logic [usc_pkg::HOUR_W-1:0] s8_hour;
  logic [usc_pkg::MIN_W-1:0]  s8_min;
  logic [usc_pkg::SEC_W-1:0]  s8_sec;
  logic [usc_pkg::WDAY_W-1:0] s8_wd;

  assign y100  = s7_p100[17:16];
  assign ybase = s7_p365 + 18'(s7_yoc[8:2]) - 18'(y100);
  assign doy8  = s7_doc - ybase;

  always_ff @(posedge clk) begin
    if (ctl.load[7]) begin
      s8_doy  <= doy8[8:0];
      s8_yoc  <= s7_yoc;
      s8_cyc5 <= s7_cyc5;
      s8_hour <= s7_hour;
      s8_min  <= s7_min;
      s8_sec  <= s7_sec;
      s8_wd   <= s7_wd;
    end
  end

  // Stage 9: March-based month as (5 * doy + 2) / 153.
  logic [10:0] v9;
  logic [22:0] s9_pm;
  logic [8:0]  s9_doy;
  logic [8:0]  s9_yoc;
  logic        s9_cyc5;
  logic [usc_pkg::HOUR_W-1:0] s9_hour;
  logic [usc_pkg::MIN_W-1:0]  s9_min;
  logic [usc_pkg::SEC_W-1:0]  s9_sec;
  logic [usc_pkg::WDAY_W-1:0] s9_wd;

  assign v9 = {s8_doy, 2'b00} + {2'b00, s8_doy} + 11'd2;

  always_ff @(posedge clk) begin
    if (ctl.load[8]) begin
      s9_pm   <= 23'(v9) * 23'(usc_pkg::RCP_153);
      s9_doy  <= s8_doy;
      s9_yoc  <= s8_yoc;
      s9_cyc5 <= s8_cyc5;
      s9_hour <= s8_hour;
      s9_min  <= s8_min;
      s9_sec  <= s8_sec;
      s9_wd   <= s8_wd;
    end
  end

  // Stage 10 (output register): day of month, civil month, year and range flag. January
  // and February close the March-based year, so they belong to the next year.
  logic [3:0]  mp10;
  logic [8:0]  dom10;
  logic [3:0]  mon10;
  logic [usc_pkg::YEAR_W-1:0] yr10;

  assign mp10  = s9_pm[22:19];
  assign dom10 = s9_doy - usc_pkg::month_start(mp10) + 9'd1;
  assign mon10 = (mp10 < usc_pkg::MP_JAN) ? mp10 + 4'd3 : mp10 - 4'd9;
  assign yr10  = 12'(s9_yoc) + (s9_cyc5 ? usc_pkg::CYC5_YEAR : usc_pkg::CYC4_YEAR)
               + 12'((mp10 >= usc_pkg::MP_JAN));

  logic [usc_pkg::YEAR_W-1:0]  out_year;
  logic [usc_pkg::MONTH_W-1:0] out_month;
  logic [usc_pkg::DAY_W-1:0]   out_day;
  logic [usc_pkg::HOUR_W-1:0]  out_hour;
  logic [usc_pkg::MIN_W-1:0]   out_min;
  logic [usc_pkg::SEC_W-1:0]   out_sec;
  logic [usc_pkg::WDAY_W-1:0]  out_wd;
  logic                        out_ok;

  always_ff @(posedge clk) begin
    if (ctl.load[9]) begin
      out_year  <= yr10;
      out_month <= mon10;
      out_day   <= dom10[4:0];
      out_hour  <= s9_hour;
      out_min   <= s9_min;
      out_sec   <= s9_sec;
      out_wd    <= s9_wd;
      out_ok    <= (yr10 >= usc_pkg::YEAR_LO) && (yr10 <= usc_pkg::YEAR_HI);
    end
  end

  assign calendar.year     = out_year;
  assign calendar.month    = out_month;
  assign calendar.day      = out_day;
  assign calendar.hour     = out_hour;
  assign calendar.minute   = out_min;
  assign calendar.second   = out_sec;
  assign calendar.weekday  = out_wd;
  assign calendar.in_range = out_ok;

endmodule

// File: design/usc_checker.sv
// Port-level assertions for the converter, bound to its top level.
`timescale 1ns / 1ps
module usc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [usc_pkg::YEAR_W-1:0]  year,
  input logic [usc_pkg::MONTH_W-1:0] month,
  input logic [usc_pkg::DAY_W-1:0]   day,
  input logic [usc_pkg::HOUR_W-1:0]  hour,
  input logic [usc_pkg::MIN_W-1:0]   minute,
  input logic [usc_pkg::SEC_W-1:0]   second,
  input logic [usc_pkg::WDAY_W-1:0]  weekday,
  input logic                        in_range
);

  // A word held on a stalled output does not change.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(year) && $stable(month)
      && $stable(day) && $stable(hour) && $stable(minute) && $stable(second)
      && $stable(weekday) && $stable(in_range))
    else $error("stalled calendar word changed");

  // With nothing on the output the whole pipeline can move, so input is open.
  a_open: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while output is empty");

  // Reset empties the pipeline.
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Delivered fields are in range, day only from below; in_range matches year.
  a_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> month >= 4'd1 && month <= 4'd12 && day >= 5'd1
      && weekday >= 3'd1 && weekday <= 3'd7 && hour <= 5'd23 && minute <= 6'd59
      && second <= 6'd59 && year >= 12'd1970
      && in_range == (year >= usc_pkg::YEAR_LO && year <= usc_pkg::YEAR_HI))
    else $error("calendar word out of range");

endmodule

bind unix_seconds_to_calendar usc_checker u_usc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (stamp.ready),
  .out_valid (calendar.valid),
  .out_ready (calendar.ready),
  .year      (calendar.year),
  .month     (calendar.month),
  .day       (calendar.day),
  .hour      (calendar.hour),
  .minute    (calendar.minute),
  .second    (calendar.second),
  .weekday   (calendar.weekday),
  .in_range  (calendar.in_range)
);
